>>> src/ost_pkg.sv
// ----------------------------------------------------------------------------
// ost_pkg
// Shared types for the ordered set table: operation and status codes,
// request and response payloads, and the per-cell control word.
// ----------------------------------------------------------------------------
package ost_pkg;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_ERASE  = 2'd1,
    FUNC_FIND   = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_PRESENT = 2'd1,
    STATUS_ABSENT  = 2'd2,
    STATUS_FULL    = 2'd3
  } status_t;

  localparam int ElementWidth   = 32;
  localparam int PositionWidth  = 4;
  localparam int OccupancyWidth = 5;

  typedef struct packed {
    func_t                    func;
    logic [ElementWidth-1:0]  element;
  } req_t;

  typedef struct packed {
    status_t                   status;
    logic [PositionWidth-1:0]  position;
    logic [OccupancyWidth-1:0] occupancy;
    logic [OccupancyWidth-1:0] peak;
    logic                      is_empty;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

>>> src/ost_chan_if.sv
// ----------------------------------------------------------------------------
// ost_chan_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface ost_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/ost_cell.sv
// ----------------------------------------------------------------------------
// ost_cell
// One slot of the table: holds a value, compares it with the key, and loads
// the key or takes its right neighbor's value.
// ----------------------------------------------------------------------------
module ost_cell
  import ost_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic             occupied,
  input  logic [WIDTH-1:0] key,
  input  logic [WIDTH-1:0] nbr,
  output logic [WIDTH-1:0] value,
  output logic             hit
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      value <= key;
    end else if (ctrl.shift) begin
      value <= nbr;
    end
  end

  assign hit = occupied && (value == key);

endmodule

>>> src/ordered_set_table.sv
// ----------------------------------------------------------------------------
// ordered_set_table
// Set of distinct values kept in insertion order, built as a row of cells.
// ----------------------------------------------------------------------------
// Each request item is insert, erase, find or clear and yields one response
// item, registered in the cycle after it is accepted. All cells compare
// against the key in parallel and erase shifts the later cells down in the
// same cycle, so one item is taken per cycle while the response register is
// free or being drained. Values use the low VALUE_WIDTH bits of element (at
// most 32). An insert of a value that is not held into a full table returns
// the full status and stores nothing. Position and occupancy wrap to their
// field widths. No clearing pass is needed after reset.
module ordered_set_table
  import ost_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  ost_chan_if.sink   req,
  ost_chan_if.source rsp
);

  localparam int StoreW = (VALUE_WIDTH < ElementWidth) ? VALUE_WIDTH : ElementWidth;
  localparam int IdxW   = $clog2(CAPACITY);
  localparam int CntW   = $clog2(CAPACITY + 1);

  logic [CntW-1:0]   count;
  logic [CntW-1:0]   count_next;
  logic [CntW-1:0]   peak;
  logic [CntW-1:0]   peak_next;
  logic              rsp_valid;
  rsp_t              rsp_data;
  rsp_t              rsp_data_next;

  logic [StoreW-1:0] key;
  logic [StoreW-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0] cell_hit;
  logic [CAPACITY-1:0] occupied;
  cell_ctrl_t        ctrl [CAPACITY];
  logic              fire;
  logic              hit;
  logic [IdxW-1:0]   slot;
  logic              full;
  logic              do_insert;
  logic              do_erase;
  status_t           status;
  logic [IdxW-1:0]   pos;
  logic [IdxW+PositionWidth-1:0]  pos_ext;
  logic [CntW+OccupancyWidth-1:0] cnt_ext;
  logic [CntW+OccupancyWidth-1:0] peak_ext;

  assign key       = req.data.element[StoreW-1:0];
  assign req.ready = !rsp_valid || rsp.ready;
  assign fire      = req.valid && req.ready;
  assign full      = (count == CntW'(CAPACITY));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [StoreW-1:0] nbr;
    if (i == CAPACITY - 1) begin : g_last
      assign nbr = cell_value[i];
    end else begin : g_mid
      assign nbr = cell_value[i+1];
    end
    ost_cell #(.WIDTH(StoreW)) u_cell (
      .clk      (clk),
      .ctrl     (ctrl[i]),
      .occupied (occupied[i]),
      .key      (key),
      .nbr      (nbr),
      .value    (cell_value[i]),
      .hit      (cell_hit[i])
    );
  end

  always_comb begin
    slot = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_hit[i]) begin
        slot = slot | IdxW'(i);
      end
    end
    hit = |cell_hit;
  end

  always_comb begin
    do_insert  = 1'b0;
    do_erase   = 1'b0;
    status     = STATUS_OK;
    pos        = '0;
    count_next = count;
    case (req.data.func)
      FUNC_INSERT: begin
        if (hit) begin
          status = STATUS_PRESENT;
          pos    = slot;
        end else if (full) begin
          status = STATUS_FULL;
        end else begin
          do_insert  = fire;
          pos        = count[IdxW-1:0];
          count_next = count + CntW'(1);
        end
      end
      FUNC_ERASE: begin
        if (hit) begin
          do_erase   = fire;
          pos        = slot;
          count_next = count - CntW'(1);
        end else begin
          status = STATUS_ABSENT;
        end
      end
      FUNC_FIND: begin
        if (hit) begin
          pos = slot;
        end else begin
          status = STATUS_ABSENT;
        end
      end
      FUNC_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
    peak_next = (count_next > peak) ? count_next : peak;
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occupied[i]   = CntW'(i) < count;
      ctrl[i].load  = do_insert && (count == CntW'(i));
      ctrl[i].shift = do_erase && (IdxW'(i) >= slot);
    end
  end

  always_comb begin
    pos_ext  = (IdxW + PositionWidth)'(pos);
    cnt_ext  = (CntW + OccupancyWidth)'(count_next);
    peak_ext = (CntW + OccupancyWidth)'(peak_next);
    rsp_data_next.status    = status;
    rsp_data_next.position  = pos_ext[PositionWidth-1:0];
    rsp_data_next.occupancy = cnt_ext[OccupancyWidth-1:0];
    rsp_data_next.peak      = peak_ext[OccupancyWidth-1:0];
    rsp_data_next.is_empty  = (count_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      peak      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (fire) begin
        count     <= count_next;
        peak      <= peak_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_data <= rsp_data_next;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  assert property (@(posedge clk) disable iff (rst) peak >= count)
    else $error("peak below occupancy");

  assert property (@(posedge clk) disable iff (rst) $onehot0(cell_hit))
    else $error("key matches more than one held slot");

  assert property (@(posedge clk) disable iff (rst)
    fire && req.data.func == FUNC_CLEAR |=> rsp.valid && rsp.data.is_empty && count == '0)
    else $error("clear did not empty the table");

  assert property (@(posedge clk) disable iff (rst)
    fire && req.data.func == FUNC_INSERT && !hit && !full |=> count == $past(count) + CntW'(1))
    else $error("insert did not grow the table");

endmodule
